[hdl/halfblock_pixel_plotter_macros.svh]
// Assertion macros shared by the plotter's checker.
`ifndef HALFBLOCK_PIXEL_PLOTTER_MACROS_SVH
`define HALFBLOCK_PIXEL_PLOTTER_MACROS_SVH

// Same-cycle implication, sampled at the rising clock edge, off during reset.
`define HPP_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled at the rising clock edge, off during reset.
`define HPP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/hpp_pkg.sv]
// Shared types and constants of the half-block pixel plotter.
package hpp_pkg;

   // Default geometry and color depth.
   localparam int GRID_COLS_DEF  = 256;
   localparam int GRID_ROWS_DEF  = 64;
   localparam int COLOR_BITS_DEF = 8;

   // Reset values of the clip rectangle.
   localparam logic [15:0] CLIP_FIRST_COL_RST = 16'sd0;
   localparam logic [15:0] CLIP_TOP_RST       = 16'sd0;
   localparam logic [14:0] CLIP_WIDTH_RST     = 15'd256;
   localparam logic [14:0] CLIP_HEIGHT_RST    = 15'd64;

   // Register indexes of the configuration port.
   typedef enum logic [1:0] {
      REG_CLIP_FIRST_COL = 2'd0,
      REG_CLIP_TOP       = 2'd1,
      REG_CLIP_WIDTH     = 2'd2,
      REG_CLIP_HEIGHT    = 2'd3
   } hpp_reg_type;

   // Verdict on one incoming item: keep it, and which half it paints.
   typedef struct packed {
      logic keep;
      logic sub;
   } hpp_verdict_type;

endpackage

[hdl/hpp_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
module hpp_ram
   #(parameter int WIDTH = 8,
     parameter int DEPTH = 16,
     localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1)
   (input  logic                   clock,
    input  logic                   wr_en,
    input  logic [AW-1:0]          wr_addr,
    input  logic [WIDTH-1:0]       wr_data,
    input  logic [AW-1:0]          rd_addr,
    output logic [WIDTH-1:0]       rd_data);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // A read at the address being written returns the old contents.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/hpp_front.sv]
// Grid and clip checks on an incoming pixel, and the cell address it maps to.
module hpp_front
   import hpp_pkg::*;
   #(parameter int GRID_COLS = GRID_COLS_DEF,
     parameter int GRID_ROWS = GRID_ROWS_DEF,
     localparam int DEPTH    = GRID_COLS * GRID_ROWS,
     localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1)
   (input  logic [15:0]         pixel_x,
    input  logic [15:0]         pixel_y,
    input  logic [15:0]         clip_first_col,
    input  logic [15:0]         clip_top,
    input  logic [14:0]         clip_width,
    input  logic [14:0]         clip_height,
    output hpp_verdict_type     verdict,
    output logic [AW-1:0]       cell_idx);

   localparam int CW    = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
   localparam int RW    = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;

   logic [14:0]        row;
   logic               in_grid;
   logic signed [16:0] col_s;
   logic signed [16:0] row_s;
   logic signed [16:0] left_s;
   logic signed [16:0] top_s;
   logic signed [16:0] right_s;
   logic signed [16:0] bottom_s;
   logic               in_clip;
   logic [CW-1:0]      col_t;
   logic [RW-1:0]      row_t;

   // Two pixel rows share one cell row; negative rows never reach the grid.
   assign row = pixel_y[15:1];
   assign in_grid = !pixel_y[15] && !pixel_x[15] &&
                    (pixel_x[14:0] < 15'(GRID_COLS)) && (row < 15'(GRID_ROWS));

   // Clip rectangle in cells; the sums are wide enough that they never wrap.
   assign col_s    = $signed({pixel_x[15], pixel_x});
   assign row_s    = $signed({2'b00, row});
   assign left_s   = $signed({clip_first_col[15], clip_first_col});
   assign top_s    = $signed({clip_top[15], clip_top});
   assign right_s  = left_s + $signed({2'b00, clip_width});
   assign bottom_s = top_s + $signed({2'b00, clip_height});
   assign in_clip  = (col_s >= left_s) && (col_s < right_s) &&
                     (row_s >= top_s) && (row_s < bottom_s);

   assign verdict.keep = in_grid && in_clip;
   assign verdict.sub  = pixel_y[0];

   // Row-major cell address.
   assign col_t    = pixel_x[CW-1:0];
   assign row_t    = row[RW-1:0];
   assign cell_idx = AW'(AW'(row_t) * AW'(GRID_COLS)) + AW'(col_t);

endmodule

[hdl/hpp_update.sv]
// Read-modify-write of one cell with write forwarding, and the result register.
module hpp_update
   import hpp_pkg::*;
   #(parameter int AW         = 14,
     parameter int COLOR_BITS = COLOR_BITS_DEF,
     localparam int CB        = COLOR_BITS,
     localparam int CELL_W    = 3 + 2 * CB)
   (input  logic                  clock,
    input  logic                  reset,
    input  logic                  in_take,
    input  hpp_verdict_type       in_verdict,
    input  logic [AW-1:0]         in_idx,
    input  logic [7:0]            in_color,
    input  logic [7:0]            in_col,
    input  logic [5:0]            in_row,
    input  logic [CELL_W-1:0]     rd_data,
    output logic                  stage_free,
    output logic                  wr_en,
    output logic [AW-1:0]         wr_addr,
    output logic [CELL_W-1:0]     wr_data,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output logic [7:0]            rsp_cell_col,
    output logic [5:0]            rsp_cell_row,
    output logic                  rsp_glyph_lower,
    output logic [7:0]            rsp_fore_color,
    output logic [7:0]            rsp_back_color,
    output logic                  rsp_back_is_default);

   // Cell layout: half-block mode, has top, has bottom, top color, bottom color.
   localparam int HALF_B = CELL_W - 1;
   localparam int TOP_B  = CELL_W - 2;
   localparam int BOT_B  = CELL_W - 3;

   logic                b_valid_ff, b_valid_in;
   logic                b_first_ff;
   logic [AW-1:0]       b_idx_ff;
   logic                b_sub_ff;
   logic [CB-1:0]       b_color_ff;
   logic [7:0]          b_col_ff;
   logic [5:0]          b_row_ff;
   logic [CELL_W-1:0]   hold_ff;
   logic                wr_valid_ff;
   logic [AW-1:0]       wr_addr_ff;
   logic [CELL_W-1:0]   wr_data_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [7:0]          col_ff;
   logic [5:0]          row_ff;
   logic                glyph_ff;
   logic [7:0]          fore_ff;
   logic [7:0]          back_ff;
   logic                back_def_ff;

   logic                out_can;
   logic                b_adv;
   logic [CELL_W-1:0]   cur;
   logic [CELL_W-1:0]   base;
   logic [CELL_W-1:0]   cell_new;
   logic                glyph;
   logic [CB-1:0]       fore;
   logic [CB-1:0]       back;
   logic                back_def;

   // The stage moves on when the result register is empty or being emptied.
   assign out_can    = !rsp_valid_ff || rsp_ready;
   assign b_adv      = b_valid_ff && out_can;
   assign stage_free = !b_valid_ff || b_adv;

   // The write made at the edge this item entered is not in the read data yet.
   always_comb begin
      if (!b_first_ff) begin
         cur = hold_ff;
      end else if (wr_valid_ff && (wr_addr_ff == b_idx_ff)) begin
         cur = wr_data_ff;
      end else begin
         cur = rd_data;
      end
   end

   // A cell not yet in half-block mode starts from a clean state.
   always_comb begin
      base     = cur[HALF_B] ? cur : '0;
      cell_new = base;
      cell_new[HALF_B] = 1'b1;
      if (b_sub_ff) begin
         cell_new[BOT_B]     = 1'b1;
         cell_new[CB-1:0]    = b_color_ff;
      end else begin
         cell_new[TOP_B]     = 1'b1;
         cell_new[2*CB-1:CB] = b_color_ff;
      end
   end

   // Glyph and colors for the updated cell.
   always_comb begin
      if (cell_new[TOP_B] && cell_new[BOT_B]) begin
         glyph    = 1'b1;
         fore     = cell_new[CB-1:0];
         back     = cell_new[2*CB-1:CB];
         back_def = 1'b0;
      end else if (cell_new[TOP_B]) begin
         glyph    = 1'b0;
         fore     = cell_new[2*CB-1:CB];
         back     = '0;
         back_def = 1'b1;
      end else begin
         glyph    = 1'b1;
         fore     = cell_new[CB-1:0];
         back     = '0;
         back_def = 1'b1;
      end
   end

   assign b_valid_in   = in_take || (b_valid_ff && !b_adv);
   assign rsp_valid_in = b_adv || (rsp_valid_ff && !rsp_ready);

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         b_first_ff   <= 1'b0;
         wr_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         b_valid_ff   <= b_valid_in;
         b_first_ff   <= in_take;
         wr_valid_ff  <= b_adv;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Item payload in the modify stage, and the cell held while it stalls.
   always_ff @(posedge clock) begin
      if (in_take) begin
         b_idx_ff   <= in_idx;
         b_sub_ff   <= in_verdict.sub;
         b_color_ff <= CB'(in_color);
         b_col_ff   <= in_col;
         b_row_ff   <= in_row;
      end
      hold_ff    <= cur;
      wr_addr_ff <= b_idx_ff;
      wr_data_ff <= cell_new;
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (b_adv) begin
         col_ff      <= b_col_ff;
         row_ff      <= b_row_ff;
         glyph_ff    <= glyph;
         fore_ff     <= 8'(fore);
         back_ff     <= 8'(back);
         back_def_ff <= back_def;
      end
   end

   assign wr_en   = b_adv;
   assign wr_addr = b_idx_ff;
   assign wr_data = cell_new;

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_cell_col        = col_ff;
   assign rsp_cell_row        = row_ff;
   assign rsp_glyph_lower     = glyph_ff;
   assign rsp_fore_color      = fore_ff;
   assign rsp_back_color      = back_ff;
   assign rsp_back_is_default = back_def_ff;

endmodule

[hdl/halfblock_pixel_plotter.sv]
// Top level of the half-block pixel plotter: registers, clearing pass, cell store.
//
// Each input item is one pixel (column, row, color). The pixel row selects
// a cell row (row / 2) and a half of that cell (low bit). Pixels with a
// negative row, outside the grid or outside the clip rectangle are dropped
// and give no result. Every other pixel rewrites its cell in the store and
// gives one result item: the cell position, the half-block glyph to draw,
// and its foreground and background colors.
// rsp_valid rises once a kept item has moved from the modify stage into the
// result register; one item per cycle is accepted while results drain. The
// cell store is a one-read, one-write RAM; the modify stage forwards its own
// last write, so back-to-back pixels on the same cell see each other.
// After reset the store is cleared one entry per cycle, all GRID_COLS *
// GRID_ROWS entries (16384 by default); req_ready stays low until it ends.
// The clip registers can be written during the pass.
// When the receiver stalls, the result register holds, the modify stage
// keeps its item, and req_ready drops until the result is taken.
module halfblock_pixel_plotter
   import hpp_pkg::*;
   #(parameter int GRID_COLS  = GRID_COLS_DEF,
     parameter int GRID_ROWS  = GRID_ROWS_DEF,
     parameter int COLOR_BITS = COLOR_BITS_DEF)
   (input  logic        clock,
    input  logic        reset,
    input  logic        req_valid,
    output logic        req_ready,
    input  logic [15:0] req_pixel_x,
    input  logic [15:0] req_pixel_y,
    input  logic [7:0]  req_pixel_color,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output logic [7:0]  rsp_cell_col,
    output logic [5:0]  rsp_cell_row,
    output logic        rsp_glyph_lower,
    output logic [7:0]  rsp_fore_color,
    output logic [7:0]  rsp_back_color,
    output logic        rsp_back_is_default,
    input  logic        csr_psel,
    input  logic        csr_penable,
    input  logic        csr_pwrite,
    input  logic [3:0]  csr_paddr,
    input  logic [31:0] csr_pwdata,
    output logic [31:0] csr_prdata,
    output logic        csr_pready);

   localparam int DEPTH  = GRID_COLS * GRID_ROWS;
   localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CELL_W = 3 + 2 * COLOR_BITS;

   logic [15:0]       clip_first_col_ff;
   logic [15:0]       clip_top_ff;
   logic [14:0]       clip_width_ff;
   logic [14:0]       clip_height_ff;
   logic              csr_wr;
   hpp_reg_type       reg_sel;

   logic              clr_busy_ff, clr_busy_in;
   logic [AW-1:0]     clr_addr_ff, clr_addr_in;

   hpp_verdict_type   verdict;
   logic [AW-1:0]     cell_idx;
   logic              accept;
   logic              in_take;
   logic              stage_free;
   logic              upd_wr_en;
   logic [AW-1:0]     upd_wr_addr;
   logic [CELL_W-1:0] upd_wr_data;
   logic              ram_wr_en;
   logic [AW-1:0]     ram_wr_addr;
   logic [CELL_W-1:0] ram_wr_data;
   logic [CELL_W-1:0] ram_rd_data;

   // Configuration port: zero-wait writes and reads.
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign reg_sel    = hpp_reg_type'(csr_paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         clip_first_col_ff <= CLIP_FIRST_COL_RST;
         clip_top_ff       <= CLIP_TOP_RST;
         clip_width_ff     <= CLIP_WIDTH_RST;
         clip_height_ff    <= CLIP_HEIGHT_RST;
      end else if (csr_wr) begin
         unique case (reg_sel)
            REG_CLIP_FIRST_COL: clip_first_col_ff <= csr_pwdata[15:0];
            REG_CLIP_TOP:       clip_top_ff       <= csr_pwdata[15:0];
            REG_CLIP_WIDTH:     clip_width_ff     <= csr_pwdata[14:0];
            REG_CLIP_HEIGHT:    clip_height_ff    <= csr_pwdata[14:0];
            default: ;
         endcase
      end
   end

   // Read data: signed registers read back sign-extended.
   always_comb begin
      unique case (reg_sel)
         REG_CLIP_FIRST_COL:
            csr_prdata = {{16{clip_first_col_ff[15]}}, clip_first_col_ff};
         REG_CLIP_TOP:    csr_prdata = {{16{clip_top_ff[15]}}, clip_top_ff};
         REG_CLIP_WIDTH:  csr_prdata = {17'd0, clip_width_ff};
         REG_CLIP_HEIGHT: csr_prdata = {17'd0, clip_height_ff};
         default:         csr_prdata = '0;
      endcase
   end

   // Clearing pass over the whole store after reset.
   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + AW'(1);
         if (clr_addr_ff == AW'(DEPTH - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // Input handshake; dropped pixels are accepted and go no further.
   assign req_ready = !clr_busy_ff && stage_free;
   assign accept    = req_valid && req_ready;
   assign in_take   = accept && verdict.keep;

   hpp_front #(
      .GRID_COLS (GRID_COLS),
      .GRID_ROWS (GRID_ROWS)
   ) u_front (
      .pixel_x        (req_pixel_x),
      .pixel_y        (req_pixel_y),
      .clip_first_col (clip_first_col_ff),
      .clip_top       (clip_top_ff),
      .clip_width     (clip_width_ff),
      .clip_height    (clip_height_ff),
      .verdict        (verdict),
      .cell_idx       (cell_idx)
   );

   // The clearing pass owns the write port until it finishes.
   assign ram_wr_en   = clr_busy_ff || upd_wr_en;
   assign ram_wr_addr = clr_busy_ff ? clr_addr_ff : upd_wr_addr;
   assign ram_wr_data = clr_busy_ff ? '0 : upd_wr_data;

   hpp_ram #(
      .WIDTH (CELL_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (cell_idx),
      .rd_data (ram_rd_data)
   );

   hpp_update #(
      .AW         (AW),
      .COLOR_BITS (COLOR_BITS)
   ) u_update (
      .clock               (clock),
      .reset               (reset),
      .in_take             (in_take),
      .in_verdict          (verdict),
      .in_idx              (cell_idx),
      .in_color            (req_pixel_color),
      .in_col              (req_pixel_x[7:0]),
      .in_row              (req_pixel_y[6:1]),
      .rd_data             (ram_rd_data),
      .stage_free          (stage_free),
      .wr_en               (upd_wr_en),
      .wr_addr             (upd_wr_addr),
      .wr_data             (upd_wr_data),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_cell_col        (rsp_cell_col),
      .rsp_cell_row        (rsp_cell_row),
      .rsp_glyph_lower     (rsp_glyph_lower),
      .rsp_fore_color      (rsp_fore_color),
      .rsp_back_color      (rsp_back_color),
      .rsp_back_is_default (rsp_back_is_default)
   );

endmodule

[hdl/hpp_checker.sv]
// Port-level checks on the plotter, bound to its top level.
`include "halfblock_pixel_plotter_macros.svh"

module hpp_checker
   (input logic clock,
    input logic reset,
    input logic req_valid,
    input logic req_ready,
    input logic rsp_valid,
    input logic rsp_ready);

   // A pending result stays offered until the receiver takes it.
   `HPP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "result dropped while stalled")

   // The store is being cleared right after reset, so no item is taken.
   `HPP_ASSERT_IMPLY(a_clear_blocks, clock, reset, $past(reset), !req_ready, "item taken during clearing pass")

   // A new result must trace back to an item accepted on the request channel.
   `HPP_ASSERT_IMPLY(a_rsp_source, clock, reset, $rose(rsp_valid), $past(req_valid && req_ready, 2), "result without an accepted item")

endmodule

bind halfblock_pixel_plotter hpp_checker u_hpp_checker (.*);

[bench/testbench.sv]
// Self-checking testbench for the half-block pixel plotter: random and directed pixels.
module testbench
   import hpp_pkg::*;
   ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CELL_TOTAL     = GRID_COLS_DEF * GRID_ROWS_DEF;
   localparam int WATCHDOG_LIMIT = 100000;
   localparam int MAX_REPORTS    = 10;

   // One pixel item as driven on the request channel.
   typedef struct packed {
      logic [15:0] x;
      logic [15:0] y;
      logic [7:0]  color;
   } pixel_type;

   // One cell write as seen on the result channel.
   typedef struct packed {
      logic [7:0] col;
      logic [5:0] row;
      logic       lower;
      logic [7:0] fore;
      logic [7:0] back;
      logic       back_def;
   } cell_write_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [15:0] req_pixel_x = '0;
   logic [15:0] req_pixel_y = '0;
   logic [7:0]  req_pixel_color = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_cell_col;
   logic [5:0]  rsp_cell_row;
   logic        rsp_glyph_lower;
   logic [7:0]  rsp_fore_color;
   logic [7:0]  rsp_back_color;
   logic        rsp_back_is_default;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // Pixels waiting to be driven and cell writes waiting to arrive.
   pixel_type      pending_pixels[$];
   cell_write_type expected_writes[$];
   int          issued_count = 0;
   int          accepted_count = 0;
   int          mismatch_count = 0;
   int          stall_cycles = 0;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   bit          req_taken = 1'b0;

   // Mirror of the clip registers and the cell store.
   int          clip_first_col_q = int'($signed(CLIP_FIRST_COL_RST));
   int          clip_top_q       = int'($signed(CLIP_TOP_RST));
   int          clip_width_q     = int'(CLIP_WIDTH_RST);
   int          clip_height_q    = int'(CLIP_HEIGHT_RST);
   bit          half_mode [CELL_TOTAL];
   bit          has_top   [CELL_TOTAL];
   bit          bottom_set[CELL_TOTAL];
   bit [7:0]    top_color [CELL_TOTAL];
   bit [7:0]    bottom_color[CELL_TOTAL];

   halfblock_pixel_plotter dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_pixel_x         (req_pixel_x),
      .req_pixel_y         (req_pixel_y),
      .req_pixel_color     (req_pixel_color),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_cell_col        (rsp_cell_col),
      .rsp_cell_row        (rsp_cell_row),
      .rsp_glyph_lower     (rsp_glyph_lower),
      .rsp_fore_color      (rsp_fore_color),
      .rsp_back_color      (rsp_back_color),
      .rsp_back_is_default (rsp_back_is_default),
      .csr_psel            (csr_psel),
      .csr_penable         (csr_penable),
      .csr_pwrite          (csr_pwrite),
      .csr_paddr           (csr_paddr),
      .csr_pwdata          (csr_pwdata),
      .csr_prdata          (csr_prdata),
      .csr_pready          (csr_pready));

   always #1 clock = ~clock;

   // Plots one pixel into the mirrored store and returns 1 with the cell
   // write it causes, or 0 when the pixel is dropped.
   function automatic bit plot_pixel(input pixel_type pix, output cell_write_type wr);
      int col;
      int row;
      int idx;
      bit lower_half;
      col = int'($signed(pix.x));
      row = int'($signed(pix.y));
      wr  = '0;
      if (row < 0)
         return 1'b0;
      lower_half = row[0];
      row = row >>> 1;
      if (col < 0 || col >= GRID_COLS_DEF || row >= GRID_ROWS_DEF)
         return 1'b0;
      if (col < clip_first_col_q || col >= clip_first_col_q + clip_width_q)
         return 1'b0;
      if (row < clip_top_q || row >= clip_top_q + clip_height_q)
         return 1'b0;
      idx = row * GRID_COLS_DEF + col;

      // A cell entering half-block mode starts out empty.
      if (!half_mode[idx]) begin
         half_mode[idx]    = 1'b1;
         has_top[idx]      = 1'b0;
         bottom_set[idx]   = 1'b0;
         top_color[idx]    = '0;
         bottom_color[idx] = '0;
      end
      if (lower_half) begin
         bottom_color[idx] = pix.color;
         bottom_set[idx]   = 1'b1;
      end else begin
         top_color[idx] = pix.color;
         has_top[idx]   = 1'b1;
      end

      // Pick the glyph and colors from the halves now set.
      wr.col = col[7:0];
      wr.row = row[5:0];
      if (has_top[idx] && bottom_set[idx]) begin
         wr.lower    = 1'b1;
         wr.fore     = bottom_color[idx];
         wr.back     = top_color[idx];
         wr.back_def = 1'b0;
      end else if (has_top[idx]) begin
         wr.lower    = 1'b0;
         wr.fore     = top_color[idx];
         wr.back_def = 1'b1;
      end else begin
         wr.lower    = 1'b1;
         wr.fore     = bottom_color[idx];
         wr.back_def = 1'b1;
      end
      return 1'b1;
   endfunction

   // Counts a failure and reports the first few.
   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("ERROR at %0t: %s", $realtime, msg);
   endtask

   // Queues one pixel for the driver.
   task automatic send_pixel(input logic [15:0] x, input logic [15:0] y,
                             input logic [7:0] color);
      pending_pixels.push_back('{x: x, y: y, color: color});
      issued_count++;
   endtask

   // Waits until every queued pixel is taken and every cell write is back,
   // then lets the pipeline drain of dropped pixels.
   task automatic wait_quiet();
      do
         @(negedge clock);
      while (accepted_count != issued_count || expected_writes.size() != 0);
      repeat (8) @(negedge clock);
   endtask

   // One register write: setup cycle, then access cycle until pready.
   task automatic write_reg(input hpp_reg_type idx, input logic [31:0] data);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do
         @(posedge clock);
      while (!csr_pready);
      case (idx)
         REG_CLIP_FIRST_COL: clip_first_col_q = int'($signed(data[15:0]));
         REG_CLIP_TOP:       clip_top_q       = int'($signed(data[15:0]));
         REG_CLIP_WIDTH:     clip_width_q     = int'(data[14:0]);
         REG_CLIP_HEIGHT:    clip_height_q    = int'(data[14:0]);
         default: ;
      endcase
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Starts a new phase: waits for the block to go idle, sets the clip
   // rectangle and the idling rates of both channels.
   task automatic set_phase(input int left, input int top, input int width,
                            input int height, input int send_pct, input int recv_pct);
      wait_quiet();
      write_reg(REG_CLIP_FIRST_COL, 32'(left));
      write_reg(REG_CLIP_TOP, 32'(top));
      write_reg(REG_CLIP_WIDTH, 32'(width));
      write_reg(REG_CLIP_HEIGHT, 32'(height));
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
   endtask

   // Random pixels: most often a small window of cells inside the visible area so
   // halves pile up on the same cells, else the whole grid, edges and noise.
   task automatic send_random(input int count);
      int lo_c;
      int hi_c;
      int lo_r;
      int hi_r;
      int x;
      int y;
      int pick;
      lo_c = (clip_first_col_q > 0) ? clip_first_col_q : 0;
      hi_c = clip_first_col_q + clip_width_q - 1;
      if (hi_c > GRID_COLS_DEF - 1)
         hi_c = GRID_COLS_DEF - 1;
      if (lo_c > hi_c) begin
         lo_c = 0;
         hi_c = GRID_COLS_DEF - 1;
      end
      lo_r = (clip_top_q > 0) ? clip_top_q : 0;
      hi_r = clip_top_q + clip_height_q - 1;
      if (hi_r > GRID_ROWS_DEF - 1)
         hi_r = GRID_ROWS_DEF - 1;
      if (lo_r > hi_r) begin
         lo_r = 0;
         hi_r = GRID_ROWS_DEF - 1;
      end
      repeat (count) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            x = lo_c + $urandom_range(0, (hi_c - lo_c < 3) ? hi_c - lo_c : 3);
            y = 2 * lo_r + $urandom_range(0, (hi_r - lo_r < 2) ? 2 * (hi_r - lo_r) + 1 : 5);
         end else if (pick < 80) begin
            x = $urandom_range(0, GRID_COLS_DEF - 1);
            y = $urandom_range(0, 2 * GRID_ROWS_DEF - 1);
         end else if (pick < 90) begin
            case ($urandom_range(0, 5))
               0: x = -1;
               1: x = 0;
               2: x = GRID_COLS_DEF - 1;
               3: x = GRID_COLS_DEF;
               4: x = lo_c;
               default: x = hi_c;
            endcase
            case ($urandom_range(0, 5))
               0: y = -1;
               1: y = 0;
               2: y = 2 * GRID_ROWS_DEF - 2;
               3: y = 2 * GRID_ROWS_DEF - 1;
               4: y = 2 * GRID_ROWS_DEF;
               default: y = 2 * hi_r + 1;
            endcase
         end else begin
            x = $urandom_range(0, 65535);
            y = $urandom_range(0, 65535);
         end
         send_pixel(16'(x), 16'(y), 8'($urandom_range(0, 255)));
      end
   endtask

   // Driver: presents the next pixel once the current one is taken, and
   // stalls the result channel at random.
   always @(negedge clock) begin
      pixel_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         if (!req_valid || req_taken) begin
            if (pending_pixels.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               nxt = pending_pixels.pop_front();
               req_valid       <= 1'b1;
               req_pixel_x     <= nxt.x;
               req_pixel_y     <= nxt.y;
               req_pixel_color <= nxt.color;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: predicts on every accepted pixel, checks every accepted cell
   // write, and ends the run when nothing moves for too long.
   always @(posedge clock) begin
      pixel_type      pix;
      cell_write_type predicted;
      cell_write_type got;
      cell_write_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && req_ready;
         if (req_valid && req_ready) begin
            pix = '{x: req_pixel_x, y: req_pixel_y, color: req_pixel_color};
            accepted_count++;
            if (plot_pixel(pix, predicted))
               expected_writes.push_back(predicted);
         end
         if (rsp_valid && rsp_ready) begin
            got = '{col: rsp_cell_col, row: rsp_cell_row, lower: rsp_glyph_lower,
                    fore: rsp_fore_color, back: rsp_back_color,
                    back_def: rsp_back_is_default};
            if (expected_writes.size() == 0) begin
               report_mismatch($sformatf("unexpected cell write col %0d row %0d", got.col,
                                         got.row));
            end else begin
               want = expected_writes.pop_front();
               if (got !== want)
                  report_mismatch($sformatf(
                     {"cell write col/row/lower/fore/back/def expected ",
                      "%0d/%0d/%0d/%h/%h/%0d, got %0d/%0d/%0d/%h/%h/%0d"},
                     want.col, want.row, want.lower, want.fore, want.back, want.back_def,
                     got.col, got.row, got.lower, got.fore, got.back, got.back_def));
            end
         end

         // Watchdog on handshakes of either channel.
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            stall_cycles = 0;
         end else begin
            stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
               $display("ERROR: timeout, no item moved for %0d cycles", WATCHDOG_LIMIT);
               $display("Mismatches found");
               $finish;
            end
         end
      end
   end

   // Stimulus: directed pixels, then random phases over several clip settings.
   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Whole grid visible: halves of a cell, grid corners, dropped pixels.
      set_phase(0, 0, 256, 64, 18, 55);
      send_pixel(16'd0, 16'd0, 8'h00);
      send_pixel(16'd0, 16'd1, 8'hFF);
      send_pixel(16'd255, 16'd127, 8'hA5);
      send_pixel(16'd255, 16'd126, 8'h5A);
      send_pixel(16'd5, 16'd3, 8'h3C);
      send_pixel(16'd5, 16'd3, 8'hC3);
      send_pixel(16'd5, 16'd2, 8'h81);
      send_pixel(16'd10, 16'hFFFF, 8'h11);
      send_pixel(16'd10, 16'h8000, 8'h22);
      send_pixel(16'hFFFF, 16'd0, 8'h33);
      send_pixel(16'd256, 16'd0, 8'h44);
      send_pixel(16'h7FFF, 16'd4, 8'h55);
      send_pixel(16'h8000, 16'd4, 8'h66);
      send_pixel(16'd0, 16'd128, 8'h77);
      send_pixel(16'd0, 16'h7FFF, 8'h88);
      send_random(300);

      // Narrow clip rectangle: pixels just inside and just outside each edge.
      set_phase(10, 5, 20, 8, 18, 55);
      send_pixel(16'd9, 16'd10, 8'h01);
      send_pixel(16'd10, 16'd10, 8'h02);
      send_pixel(16'd29, 16'd25, 8'h03);
      send_pixel(16'd30, 16'd10, 8'h04);
      send_pixel(16'd10, 16'd9, 8'h05);
      send_pixel(16'd10, 16'd26, 8'h06);
      send_pixel(16'd29, 16'd24, 8'h07);
      send_random(200);

      // Extreme register values; the first two and the zero-sized rectangles
      // clip everything.
      set_phase(-32768, -32768, 32767, 32767, 18, 55);
      send_random(40);
      set_phase(32767, 32767, 32767, 32767, 55, 18);
      send_random(40);
      set_phase(-100, -3, 32767, 32767, 55, 18);
      send_random(300);
      set_phase(0, 0, 0, 64, 55, 18);
      send_random(40);
      set_phase(0, 0, 256, 0, 0, 0);
      send_random(40);
      set_phase(200, 40, 100, 100, 0, 0);
      send_random(250);
      set_phase(-5, -5, 70, 20, 0, 0);
      send_random(250);
      set_phase(0, 0, 256, 64, 0, 0);
      send_random(140);

      wait_quiet();
      repeat (20) @(posedge clock);
      if (expected_writes.size() != 0)
         report_mismatch($sformatf("%0d cell writes never arrived", expected_writes.size()));
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

[sim.f]
+incdir+hdl
hdl/hpp_pkg.sv
hdl/hpp_ram.sv
hdl/hpp_front.sv
hdl/hpp_update.sv
hdl/halfblock_pixel_plotter.sv
hdl/hpp_checker.sv
bench/testbench.sv
